>>> hdl/acs_pkg.sv
`default_nettype none

package acs_pkg;

   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_EXEC    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } operation_type;

   localparam logic [6:0] U_NOT = 7'd12;
   localparam logic [6:0] U_ASL = 7'd14;
   localparam logic [6:0] U_ASR = 7'd15;
   localparam logic [6:0] U_ROL = 7'd16;
   localparam logic [6:0] U_ROR = 7'd17;

   localparam logic [4:0] IO_IN_INT  = 5'd6;
   localparam logic [4:0] IO_OUT_INT = 5'd7;
   localparam logic [4:0] IO_IN_CHR  = 5'd9;
   localparam logic [4:0] IO_OUT_CHR = 5'd10;

   localparam logic [3:0] A_ADD = 4'd7;
   localparam logic [3:0] A_SUB = 4'd8;
   localparam logic [3:0] A_AND = 4'd9;
   localparam logic [3:0] A_OR  = 4'd10;
   localparam logic [3:0] A_RSV = 4'd11;
   localparam logic [3:0] A_LDW = 4'd12;
   localparam logic [3:0] A_LDB = 4'd13;
   localparam logic [3:0] A_STW = 4'd14;
   localparam logic [3:0] A_STB = 4'd15;

   typedef enum logic [3:0] {
      INS_UNARY,
      INS_IN_INT,
      INS_OUT_INT,
      INS_IN_CHR,
      INS_OUT_CHR,
      INS_ALU,
      INS_ST_WORD,
      INS_ST_BYTE,
      INS_STOP
   } ins_type;

   typedef struct packed {
      ins_type ins;
      logic    imm;
      logic    rd_mem;
      logic    rd_word;
      logic    byte_opnd;
   } dec_type;

   typedef struct packed {
      logic [15:0] acc;
      logic [15:0] idx;
      logic [15:0] pc;
      logic        carry;
      logic        halt;
      logic        wr_en;
      logic        wr_word;
      logic [15:0] wr_data;
      logic        taken;
      logic        ovalid;
      logic        ochar;
      logic [15:0] oval;
   } exec_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FA,
      ST_FB,
      ST_FC,
      ST_DEC,
      ST_RDH,
      ST_RDL,
      ST_EXE,
      ST_WR2,
      ST_DONE
   } state_type;

   function automatic dec_type acs_decode(input logic [7:0] spec);
      dec_type    d;
      logic [6:0] h7;
      logic [4:0] h5;
      logic [3:0] h4;
      h7 = spec[7:1];
      h5 = spec[7:3];
      h4 = spec[7:4];
      d.imm = (spec[2:0] == 3'b000);
      if (h7 == U_NOT || h7 == U_ASL || h7 == U_ASR || h7 == U_ROL || h7 == U_ROR) begin
         d.ins = INS_UNARY;
      end else if (h5 == IO_IN_INT) begin
         d.ins = INS_IN_INT;
      end else if (h5 == IO_OUT_INT) begin
         d.ins = INS_OUT_INT;
      end else if (h5 == IO_IN_CHR) begin
         d.ins = INS_IN_CHR;
      end else if (h5 == IO_OUT_CHR) begin
         d.ins = INS_OUT_CHR;
      end else if (h4 >= A_ADD && h4 != A_RSV) begin
         if (h4 == A_STW) begin
            d.ins = INS_ST_WORD;
         end else if (h4 == A_STB) begin
            d.ins = INS_ST_BYTE;
         end else begin
            d.ins = INS_ALU;
         end
      end else begin
         d.ins = INS_STOP;
      end
      d.byte_opnd = (d.ins == INS_OUT_CHR) || (d.ins == INS_ALU && h4 == A_LDB);
      d.rd_mem    = !d.imm && (d.ins == INS_OUT_INT || d.ins == INS_OUT_CHR ||
                               d.ins == INS_ALU);
      d.rd_word   = !d.byte_opnd;
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hdl/acs_ram.sv
`default_nettype none

module acs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/acs_exec.sv
`default_nettype none

module acs_exec (
   input  wire logic [7:0]           spec,
   input  wire acs_pkg::dec_type     dec,
   input  wire logic [15:0]          operand,
   input  wire logic [15:0]          acc,
   input  wire logic [15:0]          idx,
   input  wire logic [15:0]          pc,
   input  wire logic                 carry,
   input  wire logic [15:0]          console,
   output acs_pkg::exec_res_type     res
);

   import acs_pkg::*;

   logic        sel_x;
   logic [15:0] r;
   logic [15:0] nr;
   logic [16:0] sum;

   always_comb begin
      sel_x = (dec.ins == INS_UNARY) ? spec[0] : spec[3];
      r     = sel_x ? idx : acc;
      nr    = r;
      sum   = 17'd0;

      res.acc     = acc;
      res.idx     = idx;
      res.pc      = pc + 16'd3;
      res.carry   = carry;
      res.halt    = 1'b0;
      res.wr_en   = 1'b0;
      res.wr_word = 1'b0;
      res.wr_data = r;
      res.taken   = 1'b0;
      res.ovalid  = 1'b0;
      res.ochar   = 1'b0;
      res.oval    = 16'd0;

      case (dec.ins)
         INS_UNARY: begin
            res.pc = pc + 16'd1;
            case (spec[7:1])
               U_NOT: begin
                  nr = ~r;
               end
               U_ASL: begin
                  nr        = {r[14:0], 1'b0};
                  res.carry = r[15];
               end
               U_ASR: begin
                  nr        = {r[15], r[15:1]};
                  res.carry = r[0];
               end
               U_ROL: begin
                  nr        = {r[14:0], carry};
                  res.carry = r[15];
               end
               U_ROR: begin
                  nr        = {carry, r[15:1]};
                  res.carry = r[0];
               end
               default: begin
                  nr = r;
               end
            endcase
         end
         INS_IN_INT: begin
            res.wr_en   = 1'b1;
            res.wr_word = 1'b1;
            res.wr_data = console;
            res.taken   = 1'b1;
         end
         INS_IN_CHR: begin
            res.wr_en   = 1'b1;
            res.wr_data = console;
            res.taken   = 1'b1;
         end
         INS_OUT_INT: begin
            res.ovalid = 1'b1;
            res.oval   = operand;
         end
         INS_OUT_CHR: begin
            res.ovalid = 1'b1;
            res.ochar  = 1'b1;
            res.oval   = operand;
         end
         INS_ALU: begin
            case (spec[7:4])
               A_ADD: begin
                  sum       = {1'b0, r} + {1'b0, operand};
                  nr        = sum[15:0];
                  res.carry = sum[16];
               end
               A_SUB: begin
                  sum       = {1'b0, r} + {1'b0, ~operand} + 17'd1;
                  nr        = sum[15:0];
                  res.carry = sum[16];
               end
               A_AND: begin
                  nr = r & operand;
               end
               A_OR: begin
                  nr = r | operand;
               end
               A_LDW: begin
                  nr = operand;
               end
               A_LDB: begin
                  nr = {r[15:8], operand[7:0]};
               end
               default: begin
                  nr = r;
               end
            endcase
         end
         INS_ST_WORD: begin
            res.wr_en   = 1'b1;
            res.wr_word = 1'b1;
         end
         INS_ST_BYTE: begin
            res.wr_en = 1'b1;
         end
         default: begin
            res.pc   = pc + 16'd1;
            res.halt = 1'b1;
         end
      endcase

      if (sel_x) begin
         res.idx = nr;
      end else begin
         res.acc = nr;
      end
   end

endmodule

`default_nettype wire

>>> hdl/accumulator_cpu_instruction_step_core.sv
// A small 16-bit accumulator machine over a byte-wide memory. Each request item either
// writes one memory byte, restarts the registers, fetches and runs one instruction,
// or does nothing; every item gives exactly one response item carrying the registers
// after it. All memory traffic goes through one byte-wide synchronous RAM with one
// read and one write port, so an instruction takes a state per byte it touches plus
// decode and execute: fetch, decode, operand reads where needed, execute, and a
// second write for word stores. Byte writes, restarts, no-op items and items met
// while halted go straight to done; a finished response waits in its own register
// while the next item is accepted. The memory has no reset and is not cleared.
`default_nettype none

module accumulator_cpu_instruction_step_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_load_address,
   input  wire logic [7:0]  req_load_byte,
   input  wire logic [15:0] req_console_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_acc_value,
   output logic [15:0]      rsp_index_value,
   output logic [15:0]      rsp_program_counter,
   output logic             rsp_carry_flag,
   output logic             rsp_halted,
   output logic             rsp_console_taken,
   output logic             rsp_out_valid,
   output logic             rsp_out_is_char,
   output logic [15:0]      rsp_out_value
);

   import acs_pkg::*;

   localparam int AW = MEM_ADDR_BITS;

   state_type    state_ff, state_in;
   logic [15:0]  acc_ff, acc_in;
   logic [15:0]  idx_ff, idx_in;
   logic [15:0]  pc_ff, pc_in;
   logic         carry_ff, carry_in;
   logic         halt_ff, halt_in;
   logic [15:0]  console_ff, console_in;
   logic [7:0]   spec_ff, spec_in;
   logic [15:0]  opw_ff, opw_in;
   logic [7:0]   dhi_ff, dhi_in;
   logic [7:0]   dlo_ff, dlo_in;
   logic [7:0]   wlo_ff, wlo_in;
   logic         taken_ff, taken_in;
   logic         ovalid_ff, ovalid_in;
   logic         ochar_ff, ochar_in;
   logic [15:0]  oval_ff, oval_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  rsp_acc_ff, rsp_acc_in;
   logic [15:0]  rsp_idx_ff, rsp_idx_in;
   logic [15:0]  rsp_pc_ff, rsp_pc_in;
   logic         rsp_carry_ff, rsp_carry_in;
   logic         rsp_halt_ff, rsp_halt_in;
   logic         rsp_taken_ff, rsp_taken_in;
   logic         rsp_ovalid_ff, rsp_ovalid_in;
   logic         rsp_ochar_ff, rsp_ochar_in;
   logic [15:0]  rsp_oval_ff, rsp_oval_in;

   logic         rsp_free;
   logic         take;
   logic         accept;
   dec_type      dec;
   exec_res_type ex;
   logic [15:0]  operand;
   logic [15:0]  pc_p1;
   logic [15:0]  pc_p2;
   logic [15:0]  opw_p1;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   acs_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   acs_exec u_exec (
      .spec    (spec_ff),
      .dec     (dec),
      .operand (operand),
      .acc     (acc_ff),
      .idx     (idx_ff),
      .pc      (pc_ff),
      .carry   (carry_ff),
      .console (console_ff),
      .res     (ex)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = (state_ff == ST_IDLE) || (state_ff == ST_DONE && rsp_free);
   assign req_stall = !take;
   assign accept    = req_valid && take;

   assign dec    = acs_decode(spec_ff);
   assign pc_p1  = pc_ff + 16'd1;
   assign pc_p2  = pc_ff + 16'd2;
   assign opw_p1 = opw_ff + 16'd1;

   always_comb begin
      if (dec.byte_opnd) begin
         operand = {8'h00, (dec.imm ? opw_ff[7:0] : dlo_ff)};
      end else begin
         operand = dec.imm ? opw_ff : {dhi_ff, dlo_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE && !rsp_free) begin
               state_in = ST_DONE;
            end else if (accept) begin
               if (req_operation == OP_EXEC && !halt_ff) begin
                  state_in = ST_FA;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FA: begin
            state_in = ST_FB;
         end
         ST_FB: begin
            state_in = ST_FC;
         end
         ST_FC: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (dec.rd_mem) begin
               state_in = dec.rd_word ? ST_RDH : ST_RDL;
            end else begin
               state_in = ST_EXE;
            end
         end
         ST_RDH: begin
            state_in = ST_RDL;
         end
         ST_RDL: begin
            state_in = ST_EXE;
         end
         ST_EXE: begin
            state_in = (ex.wr_en && ex.wr_word) ? ST_WR2 : ST_DONE;
         end
         ST_WR2: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = opw_ff[AW-1:0];
      mem_wdata = 8'h00;
      mem_raddr = pc_ff[AW-1:0];
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            mem_raddr = pc_ff[AW-1:0];
            if (accept && req_operation == OP_WRITE) begin
               mem_we    = 1'b1;
               mem_waddr = req_load_address[AW-1:0];
               mem_wdata = req_load_byte;
            end
         end
         ST_FA: begin
            mem_raddr = pc_p1[AW-1:0];
         end
         ST_FB: begin
            mem_raddr = pc_p2[AW-1:0];
         end
         ST_DEC: begin
            mem_raddr = opw_ff[AW-1:0];
         end
         ST_RDH: begin
            mem_raddr = opw_p1[AW-1:0];
         end
         ST_EXE: begin
            mem_we    = ex.wr_en;
            mem_waddr = opw_ff[AW-1:0];
            mem_wdata = ex.wr_word ? ex.wr_data[15:8] : ex.wr_data[7:0];
         end
         ST_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = opw_p1[AW-1:0];
            mem_wdata = wlo_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      pc_in      = pc_ff;
      carry_in   = carry_ff;
      halt_in    = halt_ff;
      console_in = console_ff;
      spec_in    = spec_ff;
      opw_in     = opw_ff;
      dhi_in     = dhi_ff;
      dlo_in     = dlo_ff;
      wlo_in     = wlo_ff;
      taken_in   = taken_ff;
      ovalid_in  = ovalid_ff;
      ochar_in   = ochar_ff;
      oval_in    = oval_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_acc_in    = rsp_acc_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_carry_in  = rsp_carry_ff;
      rsp_halt_in   = rsp_halt_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_ovalid_in = rsp_ovalid_ff;
      rsp_ochar_in  = rsp_ochar_ff;
      rsp_oval_in   = rsp_oval_ff;

      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_acc_in    = acc_ff;
         rsp_idx_in    = idx_ff;
         rsp_pc_in     = pc_ff;
         rsp_carry_in  = carry_ff;
         rsp_halt_in   = halt_ff;
         rsp_taken_in  = taken_ff;
         rsp_ovalid_in = ovalid_ff;
         rsp_ochar_in  = ochar_ff;
         rsp_oval_in   = oval_ff;
      end

      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (accept) begin
               console_in = req_console_value;
               taken_in   = 1'b0;
               ovalid_in  = 1'b0;
               ochar_in   = 1'b0;
               oval_in    = 16'd0;
               if (req_operation == OP_RESTART) begin
                  acc_in   = 16'd0;
                  idx_in   = 16'd0;
                  pc_in    = 16'd0;
                  carry_in = 1'b0;
                  halt_in  = 1'b0;
               end
            end
         end
         ST_FA: begin
            spec_in = mem_rdata;
         end
         ST_FB: begin
            opw_in = {mem_rdata, opw_ff[7:0]};
         end
         ST_FC: begin
            opw_in = {opw_ff[15:8], mem_rdata};
         end
         ST_RDH: begin
            dhi_in = mem_rdata;
         end
         ST_RDL: begin
            dlo_in = mem_rdata;
         end
         ST_EXE: begin
            acc_in    = ex.acc;
            idx_in    = ex.idx;
            pc_in     = ex.pc;
            carry_in  = ex.carry;
            halt_in   = halt_ff | ex.halt;
            wlo_in    = ex.wr_data[7:0];
            taken_in  = ex.taken;
            ovalid_in = ex.ovalid;
            ochar_in  = ex.ochar;
            oval_in   = ex.oval;
         end
         default: begin
            wlo_in = wlo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= 16'd0;
         idx_ff       <= 16'd0;
         pc_ff        <= 16'd0;
         carry_ff     <= 1'b0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         pc_ff        <= pc_in;
         carry_ff     <= carry_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      console_ff    <= console_in;
      spec_ff       <= spec_in;
      opw_ff        <= opw_in;
      dhi_ff        <= dhi_in;
      dlo_ff        <= dlo_in;
      wlo_ff        <= wlo_in;
      taken_ff      <= taken_in;
      ovalid_ff     <= ovalid_in;
      ochar_ff      <= ochar_in;
      oval_ff       <= oval_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_carry_ff  <= rsp_carry_in;
      rsp_halt_ff   <= rsp_halt_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_ochar_ff  <= rsp_ochar_in;
      rsp_oval_ff   <= rsp_oval_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_acc_value       = rsp_acc_ff;
   assign rsp_index_value     = rsp_idx_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_carry_flag      = rsp_carry_ff;
   assign rsp_halted          = rsp_halt_ff;
   assign rsp_console_taken   = rsp_taken_ff;
   assign rsp_out_valid       = rsp_ovalid_ff;
   assign rsp_out_is_char     = rsp_ochar_ff;
   assign rsp_out_value       = rsp_oval_ff;

endmodule

`default_nettype wire

>>> hdl/acs_checker.sv
`default_nettype none

module acs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_acc_value,
   input wire logic [15:0] rsp_index_value,
   input wire logic [15:0] rsp_program_counter,
   input wire logic        rsp_carry_flag,
   input wire logic        rsp_halted,
   input wire logic        rsp_console_taken,
   input wire logic        rsp_out_valid,
   input wire logic        rsp_out_is_char,
   input wire logic [15:0] rsp_out_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_acc_value) &&
         $stable(rsp_index_value) && $stable(rsp_program_counter) &&
         $stable(rsp_carry_flag) && $stable(rsp_halted) && $stable(rsp_console_taken) &&
         $stable(rsp_out_valid) && $stable(rsp_out_is_char) && $stable(rsp_out_value))
      else $error("A stalled response item was withdrawn or changed.");

   a_no_output_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> !rsp_out_is_char && rsp_out_value == 16'd0)
      else $error("Output fields are set on an item without console output.");

   a_in_or_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_console_taken |-> !rsp_out_valid)
      else $error("One instruction both took console input and gave output.");

   a_char_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_is_char |-> rsp_out_value[15:8] == 8'd0)
      else $error("A character output carries a non-zero high byte.");

endmodule

bind accumulator_cpu_instruction_step_core acs_checker u_acs_checker (.*);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import acs_pkg::*;

   typedef struct packed {
      operation_type op;
      logic [15:0]   addr;
      logic [7:0]    data;
      logic [15:0]   console;
   } request_type;

   typedef struct packed {
      logic [15:0] acc;
      logic [15:0] idx;
      logic [15:0] pc;
      logic        carry;
      logic        halt;
      logic        taken;
      logic        ovalid;
      logic        ochar;
      logic [15:0] oval;
   } cpu_state_type;

   localparam logic [7:0] SPEC_STOP = 8'h00;
   localparam int QUIET_TAIL = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_NONE;
   logic [15:0] req_load_address = 16'h0000;
   logic [7:0]  req_load_byte = 8'h00;
   logic [15:0] req_console_value = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_acc_value;
   logic [15:0] rsp_index_value;
   logic [15:0] rsp_program_counter;
   logic        rsp_carry_flag;
   logic        rsp_halted;
   logic        rsp_console_taken;
   logic        rsp_out_valid;
   logic        rsp_out_is_char;
   logic [15:0] rsp_out_value;

   request_type   pending_requests[$];
   cpu_state_type expected_states[$];
   request_type   next_req;
   cpu_state_type want;
   int            gap_left = 0;
   int            stall_left = 0;
   int            failures = 0;

   logic [7:0]  mem_image [MEM_DEPTH];
   bit          mem_known [MEM_DEPTH];
   logic [15:0] cpu_acc = 16'h0000;
   logic [15:0] cpu_idx = 16'h0000;
   logic [15:0] cpu_pc = 16'h0000;
   logic        cpu_carry = 1'b0;
   logic        cpu_halted = 1'b0;

   accumulator_cpu_instruction_step_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_load_address    (req_load_address),
      .req_load_byte       (req_load_byte),
      .req_console_value   (req_console_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_acc_value       (rsp_acc_value),
      .rsp_index_value     (rsp_index_value),
      .rsp_program_counter (rsp_program_counter),
      .rsp_carry_flag      (rsp_carry_flag),
      .rsp_halted          (rsp_halted),
      .rsp_console_taken   (rsp_console_taken),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_out_is_char     (rsp_out_is_char),
      .rsp_out_value       (rsp_out_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] peek_byte(input logic [15:0] a);
      return mem_image[a[MEM_ADDR_BITS-1:0]];
   endfunction

   function automatic logic [15:0] peek_word(input logic [15:0] a);
      return {peek_byte(a), peek_byte(a + 16'd1)};
   endfunction

   task automatic poke_byte(input logic [15:0] a, input logic [7:0] v);
      mem_image[a[MEM_ADDR_BITS-1:0]] = v;
      mem_known[a[MEM_ADDR_BITS-1:0]] = 1'b1;
   endtask

   task automatic poke_word(input logic [15:0] a, input logic [15:0] v);
      poke_byte(a, v[15:8]);
      poke_byte(a + 16'd1, v[7:0]);
   endtask

   function automatic ins_type classify(input logic [7:0] s);
      case (s[7:1])
         U_NOT, U_ASL, U_ASR, U_ROL, U_ROR: return INS_UNARY;
         default: ;
      endcase
      case (s[7:3])
         IO_IN_INT:  return INS_IN_INT;
         IO_OUT_INT: return INS_OUT_INT;
         IO_IN_CHR:  return INS_IN_CHR;
         IO_OUT_CHR: return INS_OUT_CHR;
         default: ;
      endcase
      case (s[7:4])
         A_ADD, A_SUB, A_AND, A_OR, A_LDW, A_LDB: return INS_ALU;
         A_STW:   return INS_ST_WORD;
         A_STB:   return INS_ST_BYTE;
         default: return INS_STOP;
      endcase
   endfunction

   task automatic machine_step(input request_type req);
      cpu_state_type res;
      logic [7:0]    spec;
      logic [15:0]   opw;
      logic [15:0]   src;
      logic [15:0]   reg_val;
      logic [16:0]   sum;
      logic          imm;
      res = '0;
      case (req.op)
         OP_WRITE: poke_byte(req.addr, req.data);
         OP_EXEC: if (!cpu_halted) begin
            spec = peek_byte(cpu_pc);
            opw = peek_word(cpu_pc + 16'd1);
            imm = (spec[2:0] == 3'b000);
            case (classify(spec))
               INS_UNARY: begin
                  reg_val = spec[0] ? cpu_idx : cpu_acc;
                  cpu_pc = cpu_pc + 16'd1;
                  case (spec[7:1])
                     U_NOT: reg_val = ~reg_val;
                     U_ASL: begin
                        cpu_carry = reg_val[15];
                        reg_val = {reg_val[14:0], 1'b0};
                     end
                     U_ASR: begin
                        cpu_carry = reg_val[0];
                        reg_val = {reg_val[15], reg_val[15:1]};
                     end
                     U_ROL: {cpu_carry, reg_val} = {reg_val, cpu_carry};
                     default: {reg_val, cpu_carry} = {cpu_carry, reg_val};
                  endcase
                  if (spec[0]) cpu_idx = reg_val;
                  else cpu_acc = reg_val;
               end
               INS_IN_INT: begin
                  cpu_pc = cpu_pc + 16'd3;
                  poke_word(opw, req.console);
                  res.taken = 1'b1;
               end
               INS_IN_CHR: begin
                  cpu_pc = cpu_pc + 16'd3;
                  poke_byte(opw, req.console[7:0]);
                  res.taken = 1'b1;
               end
               INS_OUT_INT: begin
                  cpu_pc = cpu_pc + 16'd3;
                  res.ovalid = 1'b1;
                  res.oval = imm ? opw : peek_word(opw);
               end
               INS_OUT_CHR: begin
                  cpu_pc = cpu_pc + 16'd3;
                  res.ovalid = 1'b1;
                  res.ochar = 1'b1;
                  res.oval = {8'h00, imm ? opw[7:0] : peek_byte(opw)};
               end
               INS_STOP: begin
                  cpu_pc = cpu_pc + 16'd1;
                  cpu_halted = 1'b1;
               end
               default: begin
                  reg_val = spec[3] ? cpu_idx : cpu_acc;
                  src = imm ? opw : peek_word(opw);
                  cpu_pc = cpu_pc + 16'd3;
                  case (spec[7:4])
                     A_ADD: begin
                        sum = {1'b0, reg_val} + {1'b0, src};
                        cpu_carry = sum[16];
                        reg_val = sum[15:0];
                     end
                     A_SUB: begin
                        sum = {1'b0, reg_val} + {1'b0, ~src} + 17'd1;
                        cpu_carry = sum[16];
                        reg_val = sum[15:0];
                     end
                     A_AND: reg_val = reg_val & src;
                     A_OR:  reg_val = reg_val | src;
                     A_LDW: reg_val = src;
                     A_LDB: reg_val[7:0] = imm ? opw[7:0] : peek_byte(opw);
                     A_STW: poke_word(opw, reg_val);
                     default: poke_byte(opw, reg_val[7:0]);
                  endcase
                  if (spec[3]) cpu_idx = reg_val;
                  else cpu_acc = reg_val;
               end
            endcase
         end
         OP_RESTART: begin
            cpu_acc = 16'h0000;
            cpu_idx = 16'h0000;
            cpu_pc = 16'h0000;
            cpu_carry = 1'b0;
            cpu_halted = 1'b0;
         end
         default: ;
      endcase
      res.acc = cpu_acc;
      res.idx = cpu_idx;
      res.pc = cpu_pc;
      res.carry = cpu_carry;
      res.halt = cpu_halted;
      pending_requests.push_back(req);
      expected_states.push_back(res);
   endtask

   task automatic send(input operation_type op, input logic [15:0] addr,
                       input logic [7:0] data, input logic [15:0] console);
      request_type req;
      req.op = op;
      req.addr = addr;
      req.data = data;
      req.console = console;
      machine_step(req);
   endtask

   task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
      send(OP_WRITE, addr, data, 16'($urandom));
   endtask

   // Memory has no reset, so every byte an instruction will read is loaded first.
   task automatic fill_unknown(input logic [15:0] addr);
      if (!mem_known[addr[MEM_ADDR_BITS-1:0]]) begin
         write_byte(addr, 8'($urandom));
      end
   endtask

   task automatic exec_step(input logic [15:0] console);
      logic [7:0]  spec;
      logic [15:0] opw;
      if (!cpu_halted) begin
         fill_unknown(cpu_pc);
         fill_unknown(cpu_pc + 16'd1);
         fill_unknown(cpu_pc + 16'd2);
         spec = peek_byte(cpu_pc);
         opw = peek_word(cpu_pc + 16'd1);
         if (spec[2:0] != 3'b000) begin
            case (classify(spec))
               INS_OUT_INT: begin
                  fill_unknown(opw);
                  fill_unknown(opw + 16'd1);
               end
               INS_OUT_CHR: fill_unknown(opw);
               INS_ALU: begin
                  fill_unknown(opw);
                  if (spec[7:4] != A_LDB) fill_unknown(opw + 16'd1);
               end
               default: ;
            endcase
         end
      end
      send(OP_EXEC, 16'($urandom), 8'($urandom), console);
   endtask

   function automatic logic [7:0] random_spec();
      logic [2:0] mode;
      logic [6:0] h7;
      logic [4:0] h5;
      logic [3:0] h4;
      mode = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'($urandom_range(1, 7));
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 4))
               0: h7 = U_NOT;
               1: h7 = U_ASL;
               2: h7 = U_ASR;
               3: h7 = U_ROL;
               default: h7 = U_ROR;
            endcase
            return {h7, 1'($urandom_range(0, 1))};
         end
         2, 3: begin
            case ($urandom_range(0, 3))
               0: h5 = IO_IN_INT;
               1: h5 = IO_OUT_INT;
               2: h5 = IO_IN_CHR;
               default: h5 = IO_OUT_CHR;
            endcase
            return {h5, mode};
         end
         9: return 8'($urandom);
         default: begin
            case ($urandom_range(0, 7))
               0: h4 = A_ADD;
               1: h4 = A_SUB;
               2: h4 = A_AND;
               3: h4 = A_OR;
               4: h4 = A_LDW;
               5: h4 = A_LDB;
               6: h4 = A_STW;
               default: h4 = A_STB;
            endcase
            return {h4, 1'($urandom_range(0, 1)), mode};
         end
      endcase
   endfunction

   function automatic logic [15:0] random_operand(input logic imm);
      if (imm) begin
         case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return 16'($urandom);
         endcase
      end
      case ($urandom_range(0, 7))
         0: return 16'hFFFF;
         1: return 16'($urandom);
         default: return 16'h0200 + 16'($urandom_range(0, 31));
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] prog_addr;
      logic [15:0] opnd;
      logic [7:0]  spec;
      int          n_ins;

      // A word load, an add with carry out, integer in and out wrapping at the top
      // address, a store in immediate mode, then stop and an execute while halted.
      write_byte(16'hFFFF, 8'h00);
      write_byte(16'h0000, {A_LDW, 1'b0, 3'b000});
      write_byte(16'h0001, 8'hFF);
      write_byte(16'h0002, 8'hFF);
      write_byte(16'h0003, {A_ADD, 1'b0, 3'b000});
      write_byte(16'h0004, 8'h00);
      write_byte(16'h0005, 8'h01);
      write_byte(16'h0006, {IO_IN_INT, 3'b001});
      write_byte(16'h0007, 8'hFF);
      write_byte(16'h0008, 8'hFF);
      write_byte(16'h0009, {IO_OUT_INT, 3'b001});
      write_byte(16'h000A, 8'hFF);
      write_byte(16'h000B, 8'hFF);
      write_byte(16'h000C, {A_STW, 1'b0, 3'b000});
      write_byte(16'h000D, 8'h02);
      write_byte(16'h000E, 8'h00);
      write_byte(16'h000F, SPEC_STOP);
      exec_step(16'h0000);
      exec_step(16'h0000);
      exec_step(16'hFFFF);
      exec_step(16'h1234);
      exec_step(16'h5678);
      exec_step(16'h9ABC);
      exec_step(16'hDEF0);
      send(OP_NONE, 16'($urandom), 8'($urandom), 16'($urandom));
      send(OP_RESTART, 16'($urandom), 8'($urandom), 16'($urandom));

      while (pending_requests.size() < 1000) begin
         prog_addr = 16'h0000;
         n_ins = $urandom_range(4, 16);
         repeat (n_ins) begin
            spec = random_spec();
            write_byte(prog_addr, spec);
            if (classify(spec) == INS_UNARY || classify(spec) == INS_STOP) begin
               prog_addr = prog_addr + 16'd1;
            end else begin
               opnd = random_operand(spec[2:0] == 3'b000);
               write_byte(prog_addr + 16'd1, opnd[15:8]);
               write_byte(prog_addr + 16'd2, opnd[7:0]);
               prog_addr = prog_addr + 16'd3;
            end
         end
         repeat ($urandom_range(2, 8)) begin
            write_byte(16'h0200 + 16'($urandom_range(0, 31)), 8'($urandom));
         end
         send(OP_RESTART, 16'($urandom), 8'($urandom), 16'($urandom));
         repeat (n_ins + $urandom_range(0, 4)) begin
            case ($urandom_range(0, 19))
               0: send(OP_NONE, 16'($urandom), 8'($urandom), 16'($urandom));
               1: write_byte(16'($urandom), 8'($urandom));
               2: send(OP_RESTART, 16'($urandom), 8'($urandom), 16'($urandom));
               default: exec_step(16'($urandom));
            endcase
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || expected_states.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("PASS accumulator_cpu_instruction_step_core");
      end else begin
         $display("FAIL accumulator_cpu_instruction_step_core");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("FAIL accumulator_cpu_instruction_step_core");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_req.op;
            req_load_address <= next_req.addr;
            req_load_byte <= next_req.data;
            req_console_value <= next_req.console;
            if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
               gap_left <= $urandom_range(1, 9);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] expd,
                              input logic [15:0] got);
      if (got !== expd) begin
         $error("%s: expected %h, actual %h", name, expd, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               $error("response item with no expectation waiting");
               failures++;
            end else begin
               want = expected_states.pop_front();
               check_field("acc_value", want.acc, rsp_acc_value);
               check_field("index_value", want.idx, rsp_index_value);
               check_field("program_counter", want.pc, rsp_program_counter);
               check_field("carry_flag", 16'(want.carry), 16'(rsp_carry_flag));
               check_field("halted", 16'(want.halt), 16'(rsp_halted));
               check_field("console_taken", 16'(want.taken), 16'(rsp_console_taken));
               check_field("out_valid", 16'(want.ovalid), 16'(rsp_out_valid));
               check_field("out_is_char", 16'(want.ochar), 16'(rsp_out_is_char));
               check_field("out_value", want.oval, rsp_out_value);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (expected_states.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
               stall_left <= $urandom_range(1, 9);
            end
         end
      end
   end

endmodule

>>> sim.f
hdl/acs_pkg.sv
hdl/acs_ram.sv
hdl/acs_exec.sv
hdl/accumulator_cpu_instruction_step_core.sv
hdl/acs_checker.sv
test/testbench.sv
